### rtl/core/iectmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iectmr_pkg
// Shared types and field widths for the IEC 61131-3 timer bank.
// ----------------------------------------------------------------------------
package iectmr_pkg;

  localparam int FUNC_W   = 3;
  localparam int IDX_W    = 4;
  localparam int DT_W     = 16;
  localparam int KIND_W   = 2;
  localparam int PRESET_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_SET_IN  = 3'd1,
    FUNC_SET_RST = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_CONFIG  = 3'd4,
    FUNC_READ    = 3'd5
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TON = 2'd0,
    KIND_TOF = 2'd1,
    KIND_TP  = 2'd2,
    KIND_RTO = 2'd3
  } kind_e;

  typedef struct packed {
    logic in_level;
    logic reset_level;
    logic q;
    logic pulse;
    logic prev_in;
  } timer_flags_t;

endpackage

### rtl/core/iectmr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iectmr_step
// Next state of one timer entry for one operation: tick, set levels, clear
// or configure; read and other codes leave it unchanged. Elapsed time saturates at the preset.
// ----------------------------------------------------------------------------
module iectmr_step import iectmr_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  func_e                func_i,
  input  logic                 level_i,
  input  kind_e                cfg_kind_i,
  input  logic [TIME_BITS-1:0] cfg_preset_i,
  input  logic [DT_W-1:0]      dt_i,
  input  kind_e                kind_i,
  input  logic [TIME_BITS-1:0] preset_i,
  input  logic [TIME_BITS-1:0] elapsed_i,
  input  timer_flags_t         flags_i,
  output kind_e                kind_o,
  output logic [TIME_BITS-1:0] preset_o,
  output logic [TIME_BITS-1:0] elapsed_o,
  output timer_flags_t         flags_o
);

  logic                 pulse_start;
  logic [TIME_BITS-1:0] el_base;
  logic [TIME_BITS-1:0] dt_ext;
  logic [TIME_BITS-1:0] room;
  logic                 reached;
  logic [TIME_BITS-1:0] adv_el;

  assign pulse_start = flags_i.in_level && !flags_i.prev_in && !flags_i.pulse;
  assign el_base     = (kind_i == KIND_TP && pulse_start) ? '0 : elapsed_i;
  assign dt_ext      = TIME_BITS'(dt_i);
  assign room        = preset_i - el_base;
  assign reached     = (el_base >= preset_i) || (dt_ext >= room);
  assign adv_el      = reached ? preset_i : el_base + dt_ext;

  always_comb begin
    kind_o    = kind_i;
    preset_o  = preset_i;
    elapsed_o = elapsed_i;
    flags_o   = flags_i;
    case (func_i)
      FUNC_TICK: begin
        case (kind_i)
          KIND_TON: begin
            if (flags_i.in_level) begin
              elapsed_o = adv_el;
              flags_o.q = reached;
            end else begin
              elapsed_o = '0;
              flags_o.q = 1'b0;
            end
          end
          KIND_TOF: begin
            if (flags_i.in_level) begin
              elapsed_o = '0;
              flags_o.q = 1'b1;
            end else begin
              elapsed_o = adv_el;
              flags_o.q = !reached;
            end
          end
          KIND_TP: begin
            if (pulse_start || flags_i.pulse) begin
              elapsed_o     = adv_el;
              flags_o.q     = !reached;
              flags_o.pulse = !reached;
            end
          end
          default: begin
            if (flags_i.reset_level) begin
              elapsed_o     = '0;
              flags_o.q     = 1'b0;
              flags_o.pulse = 1'b0;
            end else if (flags_i.in_level) begin
              elapsed_o = adv_el;
              flags_o.q = reached;
            end
          end
        endcase
        flags_o.prev_in = flags_i.in_level;
      end
      FUNC_SET_IN: begin
        flags_o.in_level = level_i;
      end
      FUNC_SET_RST: begin
        flags_o.reset_level = level_i;
      end
      FUNC_CLEAR: begin
        elapsed_o     = '0;
        flags_o.q     = 1'b0;
        flags_o.pulse = 1'b0;
      end
      FUNC_CONFIG: begin
        kind_o    = cfg_kind_i;
        preset_o  = cfg_preset_i;
        elapsed_o = '0;
        flags_o   = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/iectmr_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iectmr_state
// Per-timer register tables with one read and one write port at the same
// index, plus the configured timer count.
// ----------------------------------------------------------------------------
module iectmr_state import iectmr_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32,
  parameter int CNT_W     = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic                 wr_en_i,
  input  logic                 cnt_bump_i,
  input  kind_e                wr_kind_i,
  input  logic [TIME_BITS-1:0] wr_preset_i,
  input  logic [TIME_BITS-1:0] wr_elapsed_i,
  input  timer_flags_t         wr_flags_i,
  output kind_e                rd_kind_o,
  output logic [TIME_BITS-1:0] rd_preset_o,
  output logic [TIME_BITS-1:0] rd_elapsed_o,
  output timer_flags_t         rd_flags_o,
  output logic [CNT_W-1:0]     count_o
);

  localparam int EIDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  kind_e                kind_mem_q    [ENTRIES];
  logic [TIME_BITS-1:0] preset_mem_q  [ENTRIES];
  logic [TIME_BITS-1:0] elapsed_mem_q [ENTRIES];
  timer_flags_t         flags_mem_q   [ENTRIES];
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_d;
  logic [EIDX_W-1:0]    eidx;

  assign eidx = idx_i[EIDX_W-1:0];

  assign rd_kind_o    = kind_mem_q[eidx];
  assign rd_preset_o  = preset_mem_q[eidx];
  assign rd_elapsed_o = elapsed_mem_q[eidx];
  assign rd_flags_o   = flags_mem_q[eidx];
  assign count_o      = count_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      kind_mem_q[eidx]    <= wr_kind_i;
      preset_mem_q[eidx]  <= wr_preset_i;
      elapsed_mem_q[eidx] <= wr_elapsed_i;
      flags_mem_q[eidx]   <= wr_flags_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cnt_bump_i && ((IDX_W+1)'(idx_i) >= (IDX_W+1)'(count_q))) begin
      count_d = CNT_W'((IDX_W+1)'(idx_i) + (IDX_W+1)'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

### rtl/core/iec_timer_bank_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iec_timer_bank_top
// Bank of IEC 61131-3 timers (TON, TOF, TP, RTO) driven by one operation
// per beat; every beat returns the addressed timer's output and an index
// error flag.
//
//   Channel | Dir | Handshake                 | Fields
//   --------+-----+---------------------------+---------------------------------
//   in      | in  | in_valid_i / in_ready_o   | func, timer_index, tick_time,
//           |     |                           | level, timer_kind, preset_time
//   out     | out | out_valid_o / out_ready_i | q_out, bad_index
//
// A beat is registered on accept and moves on when the result register is
// free or read out; one beat per cycle sustained while out_ready_i is high.
// The table read-modify-write happens as the beat moves into the result
// register, so back-to-back beats on one timer see each other's updates.
// in_ready_o drops only while both the input and result registers are
// held by a stall on out_ready_i.
// Reset clears valids and the timer count; tables are undefined until
// configured.
// ----------------------------------------------------------------------------
module iec_timer_bank_top import iectmr_pkg::*; #(
  parameter int BANK_SIZE = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [IDX_W-1:0]    timer_index_i,
  input  logic [DT_W-1:0]     tick_time_i,
  input  logic                level_i,
  input  logic [KIND_W-1:0]   timer_kind_i,
  input  logic [PRESET_W-1:0] preset_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                q_out_o,
  output logic                bad_index_o
);

  localparam int ENTRIES = (BANK_SIZE < 2**IDX_W) ? BANK_SIZE : 2**IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  logic                 in_valid_q;
  logic                 in_valid_d;
  logic [FUNC_W-1:0]    func_q;
  logic [IDX_W-1:0]     idx_q;
  logic [DT_W-1:0]      dt_q;
  logic                 level_q;
  kind_e                kind_q;
  logic [TIME_BITS-1:0] preset_q;

  logic                 out_valid_q;
  logic                 out_valid_d;
  logic                 q_out_q;
  logic                 bad_q;

  logic                 in_fire;
  logic                 advance;
  func_e                func;
  logic                 is_cfg;
  logic                 bad;
  logic [CNT_W-1:0]     count;

  kind_e                rd_kind;
  logic [TIME_BITS-1:0] rd_preset;
  logic [TIME_BITS-1:0] rd_elapsed;
  timer_flags_t         rd_flags;
  kind_e                nx_kind;
  logic [TIME_BITS-1:0] nx_preset;
  logic [TIME_BITS-1:0] nx_elapsed;
  timer_flags_t         nx_flags;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign func   = func_e'(func_q);
  assign is_cfg = (func == FUNC_CONFIG);
  assign bad    = is_cfg ? (32'(idx_q) >= BANK_SIZE)
                         : ((32'(idx_q) >= BANK_SIZE) ||
                            ((IDX_W+1)'(idx_q) >= (IDX_W+1)'(count)));

  iectmr_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .func_i       (func),
    .level_i      (level_q),
    .cfg_kind_i   (kind_q),
    .cfg_preset_i (preset_q),
    .dt_i         (dt_q),
    .kind_i       (rd_kind),
    .preset_i     (rd_preset),
    .elapsed_i    (rd_elapsed),
    .flags_i      (rd_flags),
    .kind_o       (nx_kind),
    .preset_o     (nx_preset),
    .elapsed_o    (nx_elapsed),
    .flags_o      (nx_flags)
  );

  iectmr_state #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS),
    .CNT_W     (CNT_W)
  ) u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .idx_i        (idx_q),
    .wr_en_i      (advance && !bad),
    .cnt_bump_i   (advance && !bad && is_cfg),
    .wr_kind_i    (nx_kind),
    .wr_preset_i  (nx_preset),
    .wr_elapsed_i (nx_elapsed),
    .wr_flags_i   (nx_flags),
    .rd_kind_o    (rd_kind),
    .rd_preset_o  (rd_preset),
    .rd_elapsed_o (rd_elapsed),
    .rd_flags_o   (rd_flags),
    .count_o      (count)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the input beat until it moves into the result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= func_i;
      idx_q    <= timer_index_i;
      dt_q     <= tick_time_i;
      level_q  <= level_i;
      kind_q   <= kind_e'(timer_kind_i);
      preset_q <= TIME_BITS'(preset_time_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      q_out_q <= bad ? 1'b0 : nx_flags.q;
      bad_q   <= bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign q_out_o     = q_out_q;
  assign bad_index_o = bad_q;

endmodule

### rtl/core/iectmr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iectmr_checker
// Port-level checks for the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module iectmr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic q_out_o,
  input logic bad_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(q_out_o) && $stable(bad_index_o))
    else $error("result beat changed while stalled");

  a_bad_q_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> !q_out_o)
    else $error("q_out set on a bad index");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without an output stall");

endmodule

bind iec_timer_bank_top iectmr_checker u_checker (.*);

### tb/tb_iec_timer_bank_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iec_timer_bank_top
// Self-checking bench for the IEC 61131-3 timer bank. A short table of
// operations covers index errors, every operation code, every timer kind and
// the field extremes; random timer sequences follow, with random idling on both
// sides in two of three phases. Every returned beat is checked against an
// in-bench model of the timer tables or a fixed value from the table.
// ----------------------------------------------------------------------------
module tb_iec_timer_bank_top;
  import iectmr_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
  localparam int NTMR        = 16;
  localparam int DIR_ROWS    = 25;
  localparam int PHASE_OPS   = 567;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [IDX_W-1:0]    idx;
    logic [DT_W-1:0]     dt;
    logic                lvl;
    logic [KIND_W-1:0]   kind;
    logic [PRESET_W-1:0] preset;
  } tmr_op_t;

  typedef struct packed {
    logic q;
    logic bad;
  } tmr_status_t;

  typedef struct packed {
    tmr_op_t     op;
    logic        fixed;
    tmr_status_t want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i;
  logic [IDX_W-1:0]    timer_index_i;
  logic [DT_W-1:0]     tick_time_i;
  logic                level_i;
  logic [KIND_W-1:0]   timer_kind_i;
  logic [PRESET_W-1:0] preset_time_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                q_out_o;
  logic                bad_index_o;

  kind_e               tmr_kind     [NTMR];
  logic [PRESET_W-1:0] tmr_preset   [NTMR];
  logic [PRESET_W-1:0] tmr_elapsed  [NTMR];
  logic                tmr_in       [NTMR];
  logic                tmr_rst      [NTMR];
  logic                tmr_q        [NTMR];
  logic                tmr_pulse    [NTMR];
  logic                tmr_prev_in  [NTMR];
  logic                tmr_configured [NTMR];
  int unsigned         tmr_count;

  tmr_status_t status_fifo [$];
  tmr_status_t status_exp;
  int          fail_count;
  int          idle_cycles;
  int          tx_idle_pct;
  int          rx_idle_pct;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{'{FUNC_TICK,    4'd0,  16'hFFFF, 1'b0, KIND_TON, 32'd0},         1'b1, '{1'b0, 1'b1}},
    '{'{FUNC_RSVD7,   4'd15, 16'h0000, 1'b0, KIND_TON, 32'd0},         1'b1, '{1'b0, 1'b1}},
    '{'{FUNC_CONFIG,  4'd0,  16'h0000, 1'b0, KIND_TON, 32'd0},         1'b1, '{1'b0, 1'b0}},
    '{'{FUNC_SET_IN,  4'd0,  16'h0000, 1'b1, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_TICK,    4'd0,  16'h0000, 1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_CONFIG,  4'd1,  16'h0000, 1'b0, KIND_TOF, 32'hFFFFFFFF},  1'b1, '{1'b0, 1'b0}},
    '{'{FUNC_TICK,    4'd1,  16'hFFFF, 1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_SET_IN,  4'd1,  16'h0000, 1'b1, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_TICK,    4'd1,  16'h0000, 1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_CONFIG,  4'd2,  16'h0000, 1'b0, KIND_TP,  32'd5},         1'b1, '{1'b0, 1'b0}},
    '{'{FUNC_SET_IN,  4'd2,  16'h0000, 1'b1, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_TICK,    4'd2,  16'd3,    1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_TICK,    4'd2,  16'd3,    1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_TICK,    4'd2,  16'd3,    1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_CLEAR,   4'd2,  16'h0000, 1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_CONFIG,  4'd3,  16'h0000, 1'b0, KIND_RTO, 32'd10},        1'b1, '{1'b0, 1'b0}},
    '{'{FUNC_SET_IN,  4'd3,  16'h0000, 1'b1, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_TICK,    4'd3,  16'd10,   1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_SET_IN,  4'd3,  16'h0000, 1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_TICK,    4'd3,  16'd7,    1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_SET_RST, 4'd3,  16'h0000, 1'b1, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_TICK,    4'd3,  16'd5,    1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_READ,    4'd3,  16'h0000, 1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_RSVD6,   4'd1,  16'h0000, 1'b0, KIND_TON, 32'd0},         1'b0, '{1'b0, 1'b0}},
    '{'{FUNC_CLEAR,   4'd4,  16'h0000, 1'b0, KIND_TON, 32'd0},         1'b1, '{1'b0, 1'b1}}
  };

  iec_timer_bank_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .timer_index_i (timer_index_i),
    .tick_time_i   (tick_time_i),
    .level_i       (level_i),
    .timer_kind_i  (timer_kind_i),
    .preset_time_i (preset_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .q_out_o       (q_out_o),
    .bad_index_o   (bad_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit saturate_elapsed(int unsigned i, logic [DT_W-1:0] dt);
    if (tmr_elapsed[i] >= tmr_preset[i] ||
        {{(PRESET_W-DT_W){1'b0}}, dt} >= tmr_preset[i] - tmr_elapsed[i]) begin
      tmr_elapsed[i] = tmr_preset[i];
      return 1'b1;
    end
    tmr_elapsed[i] = tmr_elapsed[i] + {{(PRESET_W-DT_W){1'b0}}, dt};
    return 1'b0;
  endfunction

  function automatic tmr_status_t timer_bank_step(tmr_op_t op);
    tmr_status_t r;
    int unsigned i;
    logic        in_lvl;
    r = '0;
    i = op.idx;
    if (op.func == FUNC_CONFIG) begin
      tmr_kind[i]       = kind_e'(op.kind);
      tmr_preset[i]     = op.preset;
      tmr_elapsed[i]    = '0;
      tmr_in[i]         = 1'b0;
      tmr_rst[i]        = 1'b0;
      tmr_q[i]          = 1'b0;
      tmr_pulse[i]      = 1'b0;
      tmr_prev_in[i]    = 1'b0;
      tmr_configured[i] = 1'b1;
      if (i >= tmr_count) tmr_count = i + 1;
      return r;
    end
    if (i >= tmr_count) begin
      r.bad = 1'b1;
      return r;
    end
    case (op.func)
      FUNC_TICK: begin
        in_lvl = tmr_in[i];
        case (tmr_kind[i])
          KIND_TON: begin
            if (in_lvl) begin
              tmr_q[i] = saturate_elapsed(i, op.dt);
            end else begin
              tmr_elapsed[i] = '0;
              tmr_q[i]       = 1'b0;
            end
          end
          KIND_TOF: begin
            if (in_lvl) begin
              tmr_elapsed[i] = '0;
              tmr_q[i]       = 1'b1;
            end else begin
              tmr_q[i] = !saturate_elapsed(i, op.dt);
            end
          end
          KIND_TP: begin
            if (in_lvl && !tmr_prev_in[i] && !tmr_pulse[i]) begin
              tmr_elapsed[i] = '0;
              tmr_q[i]       = 1'b1;
              tmr_pulse[i]   = 1'b1;
            end
            if (tmr_pulse[i]) begin
              if (saturate_elapsed(i, op.dt)) begin
                tmr_q[i]     = 1'b0;
                tmr_pulse[i] = 1'b0;
              end else begin
                tmr_q[i] = 1'b1;
              end
            end
          end
          default: begin
            if (tmr_rst[i]) begin
              tmr_elapsed[i] = '0;
              tmr_q[i]       = 1'b0;
              tmr_pulse[i]   = 1'b0;
            end else if (in_lvl) begin
              tmr_q[i] = saturate_elapsed(i, op.dt);
            end
          end
        endcase
        tmr_prev_in[i] = in_lvl;
      end
      FUNC_SET_IN:  tmr_in[i] = op.lvl;
      FUNC_SET_RST: tmr_rst[i] = op.lvl;
      FUNC_CLEAR: begin
        tmr_elapsed[i] = '0;
        tmr_q[i]       = 1'b0;
        tmr_pulse[i]   = 1'b0;
      end
      default: ;
    endcase
    r.q = tmr_q[i];
    return r;
  endfunction

  task automatic send_op(input tmr_op_t op, input logic fixed, input tmr_status_t want);
    tmr_status_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= op.func;
    timer_index_i <= op.idx;
    tick_time_i   <= op.dt;
    level_i       <= op.lvl;
    timer_kind_i  <= op.kind;
    preset_time_i <= op.preset;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = timer_bank_step(op);
    status_fifo.push_back(fixed ? want : predicted);
  endtask

  // receiver: long hold-off first so the bank backs up, then random stalls
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_fifo.size() == 0) begin
        $display("%0t: unexpected beat q_out=%0b bad_index=%0b",
                 $time, q_out_o, bad_index_o);
        fail_count++;
      end else begin
        status_exp = status_fifo.pop_front();
        if (q_out_o !== status_exp.q) begin
          $display("%0t: q_out mismatch expected %0b actual %0b",
                   $time, status_exp.q, q_out_o);
          fail_count++;
        end
        if (bad_index_o !== status_exp.bad) begin
          $display("%0t: bad_index mismatch expected %0b actual %0b",
                   $time, status_exp.bad, bad_index_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    tmr_op_t op;
    int      roll;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = '0;
    timer_index_i = '0;
    tick_time_i   = '0;
    level_i       = 1'b0;
    timer_kind_i  = '0;
    preset_time_i = '0;
    fail_count    = 0;
    idle_cycles   = 0;
    tmr_count     = 0;
    tx_idle_pct   = 27;
    rx_idle_pct   = 58;
    for (int i = 0; i < NTMR; i++) begin
      tmr_kind[i]       = KIND_TON;
      tmr_preset[i]     = '0;
      tmr_elapsed[i]    = '0;
      tmr_in[i]         = 1'b0;
      tmr_rst[i]        = 1'b0;
      tmr_q[i]          = 1'b0;
      tmr_pulse[i]      = 1'b0;
      tmr_prev_in[i]    = 1'b0;
      tmr_configured[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[n]) send_op(dir_tbl[n].op, dir_tbl[n].fixed, dir_tbl[n].want);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 58 : 0;
      rx_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 27 : 0;
      repeat (PHASE_OPS) begin
        roll = $urandom_range(0, 9);
        op.dt = (roll < 7) ? 16'($urandom_range(0, 60)) :
                (roll < 9) ? 16'($urandom_range(0, 65535)) :
                ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        roll = $urandom_range(0, 9);
        op.preset = (roll < 6) ? 32'($urandom_range(0, 200)) :
                    (roll < 8) ? 32'($urandom_range(0, 100000)) :
                    (roll < 9) ? 32'd0 : 32'($urandom);
        op.lvl  = 1'($urandom_range(0, 1));
        op.kind = 2'($urandom_range(0, 3));
        op.idx  = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
                                              : 4'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          op.func = FUNC_TICK;
        end else if (roll < 60) begin
          op.func = FUNC_SET_IN;
        end else if (roll < 68) begin
          op.func = FUNC_SET_RST;
          op.lvl  = ($urandom_range(0, 3) == 0);
        end else if (roll < 73) begin
          op.func = FUNC_CLEAR;
        end else if (roll < 80) begin
          op.func = FUNC_CONFIG;
        end else if (roll < 92) begin
          roll    = $urandom_range(0, 2);
          op.func = (roll == 0) ? FUNC_READ : (roll == 1) ? FUNC_RSVD6 : FUNC_RSVD7;
        end else begin
          op.func   = 3'($urandom_range(0, 7));
          op.idx    = 4'($urandom_range(0, 15));
          op.dt     = 16'($urandom_range(0, 65535));
          op.preset = 32'($urandom);
        end
        // configure a timer before its first use below the timer count
        if (op.func != FUNC_CONFIG && op.idx < tmr_count && !tmr_configured[op.idx]) begin
          op.func = FUNC_CONFIG;
        end
        send_op(op, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (status_fifo.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/iectmr_pkg.sv
rtl/core/iectmr_step.sv
rtl/core/iectmr_state.sv
rtl/core/iec_timer_bank_top.sv
rtl/core/iectmr_checker.sv
tb/tb_iec_timer_bank_top.sv
